// ===== sv/cnpa_pkg.sv =====
// Package for the cross neighbour point average block.
// Holds field widths, reset values, register indexes and item codes.
// No dependencies.
package cnpa_pkg;

  localparam int MAX_POINTS_DEF = 524288;
  localparam int COORD_BITS_DEF = 32;

  localparam int WIDTH_BITS    = 13;
  localparam int POINTS_BITS   = 20;
  localparam int PIX_BITS      = 13;
  localparam int LOAD_IDX_BITS = 19;
  localparam int CNT_BITS      = 3;
  // signed linear index: row*width needs 27 bits, plus column and +-width
  localparam int IDX_BITS      = 30;
  // quotient bits resolved per divider cycle
  localparam int DIV_BITS      = 4;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 13'd960;
  localparam logic [POINTS_BITS-1:0] POINTS_RESET = 20'd518400;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_POINTS = 1'b1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CNT_BITS-1:0] NB_CENTER = 3'd0;
  localparam logic [CNT_BITS-1:0] NB_RIGHT  = 3'd1;
  localparam logic [CNT_BITS-1:0] NB_LEFT   = 3'd2;
  localparam logic [CNT_BITS-1:0] NB_BELOW  = 3'd3;
  localparam logic [CNT_BITS-1:0] NB_ABOVE  = 3'd4;

  localparam logic [CNT_BITS-1:0] MAX_USED = 3'd5;

endpackage

// ===== sv/cross_neighbour_point_average.sv =====
// Top level of the cross neighbour point average block: point store,
// index sequencer, accumulators and a 4-bit-per-cycle divider with one lane per axis.
// Depends on cnpa_pkg.
//
//  channel | ports                        | handshake
//  --------+------------------------------+-------------------------------
//  input   | start, busy, in_*            | taken when start && !busy
//  result  | out_strobe, out_*            | valid one cycle, no back-pressure
//  config  | cfg_we, cfg_index, cfg_data  | written when cfg_we
//
// A load item does not raise busy and gives no result.
// A query item keeps busy high through one multiply, one add, five store reads
// on the single read port, one drain, one setup, the divider steps and one sign
// fix-up; out_strobe follows.
// Reset is synchronous; contents of the store are undefined until loaded.
// The receiver cannot stall; each result is shown for exactly one cycle.
module cross_neighbour_point_average
  import cnpa_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic [LOAD_IDX_BITS-1:0]      in_load_index,
  input  logic signed [COORD_BITS-1:0]  in_load_x,
  input  logic signed [COORD_BITS-1:0]  in_load_y,
  input  logic signed [COORD_BITS-1:0]  in_load_z,
  input  logic                          in_load_valid,
  input  logic signed [PIX_BITS-1:0]    in_pixel_x,
  input  logic signed [PIX_BITS-1:0]    in_pixel_y,
  output logic                          out_strobe,
  output logic                          out_found,
  output logic signed [COORD_BITS-1:0]  out_mean_x,
  output logic signed [COORD_BITS-1:0]  out_mean_y,
  output logic signed [COORD_BITS-1:0]  out_mean_z,
  output logic [CNT_BITS-1:0]           out_used_count,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [POINTS_BITS-1:0]        cfg_data
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int MW     = 3 * COORD_BITS + 1;
  localparam int SW     = COORD_BITS + 3;
  localparam int DSTEPS = (SW + DIV_BITS - 1) / DIV_BITS;
  localparam int QW     = DSTEPS * DIV_BITS;
  localparam int DCW    = $clog2(DSTEPS + 1);
  localparam int LXW    = ((AW > LOAD_IDX_BITS) ? AW : LOAD_IDX_BITS) + 1;
  localparam int IW     = IDX_BITS;
  localparam int PW     = PIX_BITS + WIDTH_BITS + 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_BASE = 8'b0000_0100,
    ST_READ = 8'b0000_1000,
    ST_LAST = 8'b0001_0000,
    ST_PREP = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [WIDTH_BITS-1:0]    cloud_width_r;
  logic [POINTS_BITS-1:0]   cloud_points_r;
  logic signed [PIX_BITS-1:0] px_r, py_r;
  logic signed [IW-1:0]     prod_r, base_r;
  logic [CNT_BITS-1:0]      k_r;
  logic [MW-1:0]            mem [MAX_POINTS];
  logic [MW-1:0]            rd_data_r;
  logic                     hit_r;
  logic signed [SW-1:0]     sum_r [3];
  logic [CNT_BITS-1:0]      cnt_r;
  logic [QW-1:0]            mag_r [3];
  logic [QW-1:0]            mag_nxt [3];
  logic [2:0]               rem_r [3];
  logic [2:0]               rem_nxt [3];
  logic                     neg_r [3];
  logic [DCW-1:0]           dcnt_r;
  logic                     out_strobe_r;
  logic                     out_found_r;
  logic [COORD_BITS-1:0]    out_mean_r [3];
  logic [CNT_BITS-1:0]      out_used_r;

  logic                     accept;
  logic [LXW-1:0]           ld_ext;
  logic                     ld_ok;
  logic signed [PW-1:0]     prod_c;
  logic signed [IW-1:0]     width_s;
  logic signed [IW-1:0]     off;
  logic signed [IW-1:0]     idx;
  logic                     usable;
  logic                     rd_en;
  logic [COORD_BITS-1:0]    coord [3];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign ld_ext = LXW'(in_load_index);
  assign ld_ok  = ld_ext < LXW'(MAX_POINTS);

  assign prod_c  = py_r * $signed({1'b0, cloud_width_r});
  assign width_s = IW'($signed({1'b0, cloud_width_r}));

  always_comb begin
    case (k_r)
      NB_CENTER: off = '0;
      NB_RIGHT:  off = IW'(1);
      NB_LEFT:   off = -IW'(1);
      NB_BELOW:  off = width_s;
      NB_ABOVE:  off = -width_s;
      default:   off = '0;
    endcase
  end

  assign idx    = base_r + off;
  assign usable = !idx[IW-1]
                  && (idx[IW-2:0] < (IW-1)'(cloud_points_r))
                  && (idx[IW-2:0] < (IW-1)'(MAX_POINTS));
  assign rd_en  = (state_r == ST_READ) && usable;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action == ACT_QUERY) state_nxt = ST_MUL;
      end
      ST_MUL:  state_nxt = ST_BASE;
      ST_BASE: state_nxt = ST_READ;
      ST_READ: begin
        if (k_r == NB_ABOVE) state_nxt = ST_LAST;
      end
      ST_LAST: state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == DCW'(DSTEPS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // one divider step per lane: DIV_BITS restoring steps on a 3-bit remainder
  always_comb begin
    logic [3:0]    t;
    logic [2:0]    r;
    logic [QW-1:0] m;
    for (int l = 0; l < 3; l++) begin
      r = rem_r[l];
      m = mag_r[l];
      for (int j = 0; j < DIV_BITS; j++) begin
        t = {r, m[QW-1]};
        m = {m[QW-2:0], 1'b0};
        if (t >= {1'b0, cnt_r}) begin
          t    = t - {1'b0, cnt_r};
          m[0] = 1'b1;
        end
        r = t[2:0];
      end
      rem_nxt[l] = r;
      mag_nxt[l] = m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cloud_width_r  <= WIDTH_RESET;
      cloud_points_r <= POINTS_RESET;
      k_r            <= '0;
      hit_r          <= 1'b0;
      cnt_r          <= '0;
      dcnt_r         <= '0;
      out_strobe_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hit_r        <= rd_en;
      out_strobe_r <= (state_r == ST_FIN);
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  cloud_width_r  <= cfg_data[WIDTH_BITS-1:0];
          CFG_POINTS: cloud_points_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_BASE) k_r <= NB_CENTER;
      else if (state_r == ST_READ) k_r <= k_r + 3'd1;
      if (state_r == ST_MUL) cnt_r <= '0;
      else if (hit_r && rd_data_r[MW-1]) cnt_r <= cnt_r + 3'd1;
      if (state_r == ST_PREP) dcnt_r <= '0;
      else if (state_r == ST_DIV) dcnt_r <= dcnt_r + DCW'(1);
    end
  end

  // point store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && in_action == ACT_LOAD && ld_ok) begin
      mem[ld_ext[AW-1:0]] <= {in_load_valid, in_load_z, in_load_y, in_load_x};
    end
    if (rd_en) rd_data_r <= mem[idx[AW-1:0]];
  end

  assign coord[0] = rd_data_r[COORD_BITS-1:0];
  assign coord[1] = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign coord[2] = rd_data_r[3*COORD_BITS-1:2*COORD_BITS];

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] a;
    logic [QW-1:0]        q;
    if (accept) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (state_r == ST_MUL) prod_r <= IW'(prod_c);
    if (state_r == ST_BASE) base_r <= prod_r + IW'(px_r);
    for (int l = 0; l < 3; l++) begin
      if (state_r == ST_MUL) begin
        sum_r[l] <= '0;
      end else if (hit_r && rd_data_r[MW-1]) begin
        sum_r[l] <= sum_r[l] + SW'($signed(coord[l]));
      end
      if (state_r == ST_PREP) begin
        a = sum_r[l][SW-1] ? -sum_r[l] : sum_r[l];
        neg_r[l] <= sum_r[l][SW-1];
        mag_r[l] <= QW'($unsigned(a));
        rem_r[l] <= '0;
      end else if (state_r == ST_DIV) begin
        mag_r[l] <= mag_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
      if (state_r == ST_FIN) begin
        q = neg_r[l] ? -mag_r[l] : mag_r[l];
        out_mean_r[l] <= (cnt_r != '0) ? q[COORD_BITS-1:0] : '0;
      end
    end
    if (state_r == ST_FIN) begin
      out_found_r <= (cnt_r != '0);
      out_used_r  <= cnt_r;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_found      = out_found_r;
  assign out_mean_x     = out_mean_r[0];
  assign out_mean_y     = out_mean_r[1];
  assign out_mean_z     = out_mean_r[2];
  assign out_used_count = out_used_r;

  a_query_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == ACT_QUERY |=> busy)
    else $error("query item did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_action == ACT_LOAD |=> !busy)
    else $error("load item raised busy");

  a_result_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("query finished without a result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_USED)
    else $error("more than five points used");

  a_found_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_found == (out_used_count != '0)))
    else $error("found flag disagrees with used count");

endmodule

// ===== dv/tb_cross_neighbour_point_average.sv =====
// Testbench for cross_neighbour_point_average: loads points, runs cross
// queries under several width/count settings and checks each average.
// Depends on cnpa_pkg and the cross_neighbour_point_average RTL.
`timescale 1ns / 1ps

module tb_cross_neighbour_point_average;
  import cnpa_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int STORE_DEPTH = MAX_POINTS_DEF;
  localparam int SETTLE      = 32;
  localparam int STALL_LIMIT = 2000;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [PIX_BITS-1:0] pix_t;

  typedef struct {
    logic                     action;
    logic [LOAD_IDX_BITS-1:0] index;
    coord_t                   x, y, z;
    logic                     valid;
    pix_t                     px, py;
  } cmd_t;

  typedef struct {
    logic                found;
    coord_t              mx, my, mz;
    logic [CNT_BITS-1:0] used;
  } avg_t;

  class point_avg_scoreboard;
    longint cl_width  = WIDTH_RESET;
    longint cl_points = POINTS_RESET;
    coord_t pt_x[int], pt_y[int], pt_z[int];
    bit     pt_valid[int];
    avg_t   pending_avgs[$];
    int     mismatches, loads, queries, hits;

    function void set_reg(logic idx, logic [POINTS_BITS-1:0] v);
      if (idx == CFG_WIDTH) cl_width = v[WIDTH_BITS-1:0];
      else cl_points = v;
    endfunction

    function longint slot_of(pix_t px, pix_t py, int k);
      longint col, row;
      col = px;
      row = py;
      case (k[CNT_BITS-1:0])
        NB_RIGHT: col = col + 1;
        NB_LEFT:  col = col - 1;
        NB_BELOW: row = row + 1;
        NB_ABOVE: row = row - 1;
        default: ;
      endcase
      return row * cl_width + col;
    endfunction

    function bit in_store(longint s);
      return s >= 0 && s < cl_points && s < STORE_DEPTH;
    endfunction

    function bit loaded(longint s);
      return pt_valid.exists(int'(s));
    endfunction

    function avg_t predict_average(pix_t px, pix_t py);
      avg_t   r;
      longint sx, sy, sz, s, n;
      sx = 0; sy = 0; sz = 0; n = 0;
      for (int k = 0; k < MAX_USED; k++) begin
        s = slot_of(px, py, k);
        if (in_store(s) && loaded(s) && pt_valid[int'(s)]) begin
          sx += pt_x[int'(s)];
          sy += pt_y[int'(s)];
          sz += pt_z[int'(s)];
          n++;
        end
      end
      r.found = (n != 0);
      r.used  = n[CNT_BITS-1:0];
      r.mx    = (n == 0) ? '0 : coord_t'(sx / n);
      r.my    = (n == 0) ? '0 : coord_t'(sy / n);
      r.mz    = (n == 0) ? '0 : coord_t'(sz / n);
      return r;
    endfunction

    function void note(cmd_t c);
      if (c.action == ACT_LOAD) begin
        pt_x[c.index]     = c.x;
        pt_y[c.index]     = c.y;
        pt_z[c.index]     = c.z;
        pt_valid[c.index] = c.valid;
        loads++;
      end else begin
        pending_avgs.push_back(predict_average(c.px, c.py));
        queries++;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check(avg_t got);
      avg_t exp_r;
      if (pending_avgs.size() == 0) begin
        report($sformatf("result with no query outstanding: found=%0b used=%0d",
                         got.found, got.used));
        return;
      end
      exp_r = pending_avgs.pop_front();
      if (exp_r.found) hits++;
      if (got.found !== exp_r.found || got.used !== exp_r.used ||
          got.mx !== exp_r.mx || got.my !== exp_r.my || got.mz !== exp_r.mz)
        report($sformatf({"mismatch: found %0b/%0b used %0d/%0d x %h/%h ",
                          "y %h/%h z %h/%h (exp/act)"},
                         exp_r.found, got.found, exp_r.used, got.used,
                         exp_r.mx, got.mx, exp_r.my, got.my, exp_r.mz, got.mz));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_action;
  logic [LOAD_IDX_BITS-1:0] in_load_index;
  coord_t                   in_load_x, in_load_y, in_load_z;
  logic                     in_load_valid;
  pix_t                     in_pixel_x, in_pixel_y;
  logic                     out_strobe;
  logic                     out_found;
  coord_t                   out_mean_x, out_mean_y, out_mean_z;
  logic [CNT_BITS-1:0]      out_used_count;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [POINTS_BITS-1:0]   cfg_data;

  point_avg_scoreboard sb = new();
  avg_t seen;
  int   n_sent, n_cfg, n_drains, stall_cycles;

  cross_neighbour_point_average u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_load_index  (in_load_index),
    .in_load_x      (in_load_x),
    .in_load_y      (in_load_y),
    .in_load_z      (in_load_z),
    .in_load_valid  (in_load_valid),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .out_strobe     (out_strobe),
    .out_found      (out_found),
    .out_mean_x     (out_mean_x),
    .out_mean_y     (out_mean_y),
    .out_mean_z     (out_mean_z),
    .out_used_count (out_used_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      seen = '{out_found, out_mean_x, out_mean_y, out_mean_z, out_used_count};
      sb.check(seen);
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL cross_neighbour_point_average");
      $finish;
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return coord_t'($signed($urandom) >>> $urandom_range(8, 28));
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t rand_cmd(logic action);
    cmd_t c;
    c.action = action;
    c.index  = LOAD_IDX_BITS'($urandom);
    c.x      = rand_coord();
    c.y      = rand_coord();
    c.z      = rand_coord();
    c.valid  = 1'($urandom);
    c.px     = pix_t'($urandom);
    c.py     = pix_t'($urandom);
    return c;
  endfunction

  task automatic issue(cmd_t c);
    @(negedge clk);
    start         <= 1'b1;
    in_action     <= c.action;
    in_load_index <= c.index;
    in_load_x     <= c.x;
    in_load_y     <= c.y;
    in_load_z     <= c.z;
    in_load_valid <= c.valid;
    in_pixel_x    <= c.px;
    in_pixel_y    <= c.py;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(c);
    n_sent++;
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    pause(1);
    while (sb.pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    n_drains++;
  endtask

  task automatic write_reg(logic idx, logic [POINTS_BITS-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  task automatic load_point(longint s, coord_t x, coord_t y, coord_t z, logic v);
    cmd_t c;
    c       = rand_cmd(ACT_LOAD);
    c.index = s[LOAD_IDX_BITS-1:0];
    c.x     = x;
    c.y     = y;
    c.z     = z;
    c.valid = v;
    issue(c);
  endtask

  // loads any in-range neighbour not yet written, then sends the query
  task automatic query_at(pix_t px, pix_t py, int valid_pct);
    longint s;
    cmd_t   c;
    for (int k = 0; k < MAX_USED; k++) begin
      s = sb.slot_of(px, py, k);
      if (sb.in_store(s) && !sb.loaded(s)) begin
        c       = rand_cmd(ACT_LOAD);
        c.index = s[LOAD_IDX_BITS-1:0];
        c.valid = (int'($urandom_range(1, 100)) <= valid_pct);
        issue(c);
      end
    end
    c    = rand_cmd(ACT_QUERY);
    c.px = px;
    c.py = py;
    issue(c);
  endtask

  task automatic local_query();
    longint lim, s, w;
    int     cx, cy;
    w   = sb.cl_width;
    lim = (sb.cl_points < STORE_DEPTH) ? sb.cl_points : STORE_DEPTH;
    if (lim == 0) lim = 64;
    case ($urandom_range(0, 3))
      0: s = lim - int'($urandom_range(1, 3));
      1: s = sb.cl_points - int'($urandom_range(0, 2));
      default: s = int'($urandom_range(0, int'(lim - 1)));
    endcase
    if (w == 0) begin
      cx = int'(s) + int'($urandom_range(0, 4)) - 2;
      cy = $urandom;
    end else begin
      cx = int'(s % w) + int'($urandom_range(0, 4)) - 2;
      cy = int'(s / w) + int'($urandom_range(0, 2)) - 1;
    end
    query_at(cx[PIX_BITS-1:0], cy[PIX_BITS-1:0], 85);
  endtask

  task automatic random_items(int target);
    int first, len, r;
    first = n_sent;
    while (n_sent - first < target) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 12) issue(rand_cmd(ACT_LOAD));
        else if (r < 22) query_at(pix_t'($urandom), pix_t'($urandom), 85);
        else local_query();
      end
      if ($urandom_range(0, 14) == 0) drain();
      else pause($urandom_range(1, 24));
    end
  endtask

  task automatic configure(longint w, longint p);
    drain();
    write_reg(CFG_WIDTH, w[POINTS_BITS-1:0]);
    write_reg(CFG_POINTS, p[POINTS_BITS-1:0]);
  endtask

  // runs at reset settings: width 960, 518400 points
  task automatic directed();
    load_point(0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_8000, 1'b1);
    load_point(1, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_0000, 1'b1);
    load_point(960, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 1'b1);
    query_at(pix_t'(0), pix_t'(0), 100);
    query_at(pix_t'(-4096), pix_t'(-4096), 0);
    query_at(pix_t'(4095), pix_t'(4095), 0);
    query_at(pix_t'(5), pix_t'(0), 0);       // all neighbours NaN
    query_at(pix_t'(959), pix_t'(0), 100);   // right neighbour wraps to next row
    query_at(pix_t'(1), pix_t'(1), 100);     // full cross
    load_point(524287, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
    load_point(0, 32'h0000_0003, 32'hffff_fffd, 32'h0, 1'b0);
    query_at(pix_t'(0), pix_t'(0), 100);
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_LOAD;
    in_load_index = '0;
    in_load_x     = '0;
    in_load_y     = '0;
    in_load_z     = '0;
    in_load_valid = 1'b0;
    in_pixel_x    = '0;
    in_pixel_y    = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_WIDTH;
    cfg_data      = '0;
    stall_cycles  = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    directed();
    random_items(200);
    configure(1, 64);
    random_items(200);
    configure(0, 100);            // zero width: index is the column
    random_items(150);
    configure(4096, 524288);
    random_items(250);
    configure(8191, 20'hfffff);   // count beyond the store
    random_items(200);
    configure(7, 0);              // nothing usable
    random_items(60);
    configure(33, 2000);
    random_items(200);
    configure(4095, 300000);
    random_items(150);
    drain();

    $display("covered %0d loads and %0d queries, %0d with points averaged",
             sb.loads, sb.queries, sb.hits);
    $display("across %0d register writes and %0d idle drains; %0d mismatches",
             n_cfg, n_drains, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_avgs.size() == 0)
      $display("PASS cross_neighbour_point_average");
    else
      $display("FAIL cross_neighbour_point_average");
    $finish;
  end

endmodule
